// File: sv/ola_pkg.sv
// Package with the transaction types and codes of the ordered list block.
package ola_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_DUMP_FWD = 2'd2,
        KIND_DUMP_REV = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               item_valid;
        logic signed [31:0] item_value;
        logic [4:0]         entry_count;
        logic               last;
    } rsp_t;

endpackage

// File: sv/ola_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ola_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/ordered_list_append_remove.sv
// Top level of the bounded ordered list with append, first-match remove and dump.
//
//  channel | valid     | ready     | payload            | transaction
//  --------+-----------+-----------+--------------------+----------------------------------
//  request | req_valid | req_ready | req  (ola_pkg::req_t) | one operation on the list
//  result  | rsp_valid | rsp_ready | rsp  (ola_pkg::rsp_t) | one result, last marks the end
//
//  Append and every empty or full case give their result in the cycle after acceptance.
//  A remove scans the list through the one RAM read port, then reports from S_DONE.
//  A dump reads its entries one at a time through S_DREAD and S_DDATA; S_DREAD waits while a result is stalled.
//  A new request is taken while a result waits, as long as that result leaves this cycle.
//  Reset clears the entry count; the RAM contents are never read before they are written.
module ordered_list_append_remove #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ola_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ola_pkg::rsp_t rsp
);

    import ola_pkg::*;

    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DONE  = 5'b00100,
        S_DREAD = 5'b01000,
        S_DDATA = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic                   rev_reg, rev_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg, out_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    logic                   out_free;
    logic                   accept;
    logic                   is_full;
    logic                   cnt_zero;
    logic [AW-1:0]          cnt_last;
    logic signed [63:0]     req_ext;
    logic signed [63:0]     item_ext;
    logic                   dump_end;

    ola_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign is_full   = (cnt_reg == CW'(DEPTH));
    assign cnt_zero  = (cnt_reg == '0);
    assign cnt_last  = AW'(cnt_reg - 1'b1);
    assign req_ext   = 64'(req.value);
    assign item_ext  = 64'(signed'(rd_data));
    assign dump_end  = rev_reg ? (idx_reg == '0) : (idx_reg == cnt_last);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        rev_next       = rev_reg;
        key_next       = key_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = idx_reg - 1'b1;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.item_valid = 1'b0;
                    out_next.item_value = '0;
                    out_next.last       = 1'b1;
                    out_next.status     = ST_OK;
                    out_next.entry_count = 5'(cnt_reg);
                    key_next = req_ext[VALUE_WIDTH-1:0];
                    case (req.kind)
                        KIND_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = AW'(cnt_reg);
                                wr_data  = req_ext[VALUE_WIDTH-1:0];
                                cnt_next = cnt_reg + 1'b1;
                                out_next.entry_count = 5'(cnt_reg + 1'b1);
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (cnt_zero)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (cnt_zero)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rev_next   = (req.kind == KIND_DUMP_REV);
                                idx_next   = (req.kind == KIND_DUMP_REV) ? cnt_last : '0;
                                rd_en      = 1'b1;
                                rd_addr    = (req.kind == KIND_DUMP_REV) ? cnt_last : '0;
                                state_next = S_DDATA;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_en   = (idx_reg != cnt_last);
                rd_addr = idx_reg + 1'b1;
                if (found_reg)
                begin
                    wr_en = 1'b1;
                end
                else if (rd_data == key_reg)
                begin
                    found_next = 1'b1;
                end
                if (idx_reg == cnt_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.item_valid = 1'b0;
                    out_next.item_value = '0;
                    out_next.last       = 1'b1;
                    if (found_reg)
                    begin
                        cnt_next             = cnt_reg - 1'b1;
                        out_next.status      = ST_OK;
                        out_next.entry_count = 5'(cnt_reg - 1'b1);
                    end
                    else
                    begin
                        out_next.status      = ST_NOT_FOUND;
                        out_next.entry_count = 5'(cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            S_DREAD:
            begin
                if (out_free)
                begin
                    rd_en      = 1'b1;
                    state_next = S_DDATA;
                end
            end
            S_DDATA:
            begin
                out_valid_next       = 1'b1;
                out_next.status      = ST_OK;
                out_next.item_valid  = 1'b1;
                out_next.item_value  = item_ext[31:0];
                out_next.entry_count = 5'(cnt_reg);
                out_next.last        = dump_end;
                if (dump_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = rev_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
                    state_next = S_DREAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        found_reg <= found_next;
        rev_reg   <= rev_next;
        key_reg   <= key_next;
        out_reg   <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: sv/ola_check.sv
// Port-level checker for the ordered list block and its bind statement.
module ola_check #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input ola_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ola_pkg::rsp_t rsp
);

    import ola_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Result changed while stalled.");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.item_valid |-> rsp.last && (rsp.item_value == '0))
        else $error("A result without an entry must be the only one of its transaction.");

    a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.item_valid |-> (rsp.status == ST_OK)
                                        && ((rsp.entry_count != '0) || (DEPTH > 31)))
        else $error("A dumped entry must come with status ok from a nonempty list.");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("Request changed while waiting for acceptance.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> 32'(rsp.entry_count) == (DEPTH % 32))
        else $error("Full status with a count below the capacity.");

endmodule

bind ordered_list_append_remove ola_check #(
    .DEPTH (DEPTH)
) u_ola_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
